### hdl/lpsa_pkg.sv
// Shared types, codes and constants of the LIFO page stack allocator.
package lpsa_pkg;

    // Default sizing
    localparam int PAGE_BYTES_DEF   = 4096;
    localparam int HEADER_BYTES_DEF = 24;
    localparam int MAX_DEPTH_DEF    = 256;
    localparam int MAX_PAGES_DEF    = 64;

    // Result status codes
    localparam logic [2:0] ST_OK          = 3'd0;
    localparam logic [2:0] ST_BAD_LENGTH  = 3'd1;
    localparam logic [2:0] ST_PAGE_LIMIT  = 3'd2;
    localparam logic [2:0] ST_STACK_FULL  = 3'd3;
    localparam logic [2:0] ST_STACK_EMPTY = 3'd4;

    // Request modes
    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    // Configuration register map
    localparam int         CFG_ADDR_W      = 1;
    localparam int         CFG_DATA_W      = 12;
    localparam logic [0:0] CFG_MAX_ALLOC   = 1'b0;
    localparam logic [0:0] CFG_PAGE_LIMIT  = 1'b1;
    localparam logic [11:0] MAX_ALLOC_RST  = 12'd512;
    localparam logic [6:0]  PAGE_LIMIT_RST = 7'd64;

    typedef struct packed {
        logic        mode;
        logic [11:0] alloc_length;
    } in_item_t;

    typedef struct packed {
        logic [2:0]  status;
        logic [17:0] buffer_offset;
        logic [11:0] freed_length;
        logic        page_requested;
        logic        page_released;
    } result_t;

    // Controller to datapath
    typedef struct packed {
        logic accept;
        logic commit;
    } cmd_t;

    // Datapath to controller
    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

### hdl/lpsa_ram.sv
// Generic single-write, single-read RAM with registered read data.
module lpsa_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

### hdl/lpsa_ctrl.sv
// Controller: sequences accept and execute of one transaction at a time.
module lpsa_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  lpsa_pkg::stat_t stat,
    output lpsa_pkg::cmd_t  cmd
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_EXEC = 1'b1;

    logic state_reg;
    logic state_next;

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_ready    = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.accept = 1'b1;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                // hold until the result register can take the outcome
                if (stat.out_free) begin
                    cmd.commit = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

### hdl/lpsa_dp.sv
// Datapath: allocator state, configuration, stack RAM and result register.
module lpsa_dp #(
    parameter int PAGE_BYTES   = lpsa_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = lpsa_pkg::HEADER_BYTES_DEF,
    parameter int MAX_DEPTH    = lpsa_pkg::MAX_DEPTH_DEF,
    parameter int MAX_PAGES    = lpsa_pkg::MAX_PAGES_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  lpsa_pkg::cmd_t                      cmd,
    output lpsa_pkg::stat_t                     stat,
    input  lpsa_pkg::in_item_t                  s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output lpsa_pkg::result_t                   m_data,
    input  logic                                cfg_we,
    input  logic [lpsa_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  logic [lpsa_pkg::CFG_DATA_W-1:0]     cfg_wdata
);

    localparam int USED_W  = $clog2(MAX_PAGES * PAGE_BYTES + 1);
    localparam int SUM_W   = $clog2((MAX_PAGES + 1) * PAGE_BYTES + 8192) + 1;
    localparam int PC_W    = $clog2(MAX_PAGES + 1);
    localparam int DEPTH_W = $clog2(MAX_DEPTH + 1);
    localparam int IDX_W   = $clog2(MAX_DEPTH);
    localparam int ENT_W   = 13;

    logic [11:0]          max_alloc_reg;
    logic [6:0]           page_limit_reg;
    lpsa_pkg::in_item_t   item_reg;
    logic [DEPTH_W-1:0]   depth_reg;
    logic [USED_W-1:0]    used_reg;
    logic [USED_W-1:0]    cap_reg;
    logic [PC_W-1:0]      page_count_reg;
    logic                 m_valid_reg;
    lpsa_pkg::result_t    m_data_reg;

    logic [DEPTH_W-1:0]   depth_dec;
    logic [ENT_W-1:0]     ram_rdata;
    logic [11:0]          pop_len;
    logic                 pop_grew;
    logic [SUM_W-1:0]     with_hdr;
    logic [SUM_W-1:0]     sum_end;
    logic [SUM_W-1:0]     cap_grown;
    logic                 bad_len;
    logic                 stack_full;
    logic                 need_page;
    logic                 page_fail;
    logic                 alloc_ok;
    logic                 free_ok;
    lpsa_pkg::result_t    res;

    assign depth_dec = depth_reg - DEPTH_W'(1);
    assign pop_len   = ram_rdata[11:0];
    assign pop_grew  = ram_rdata[12];

    lpsa_ram #(
        .WIDTH (ENT_W),
        .DEPTH (MAX_DEPTH)
    ) u_stack (
        .aclk  (aclk),
        .we    (cmd.commit && alloc_ok),
        .waddr (depth_reg[IDX_W-1:0]),
        .wdata ({need_page, item_reg.alloc_length}),
        .re    (cmd.accept && (s_data.mode == lpsa_pkg::MODE_FREE)),
        .raddr (depth_dec[IDX_W-1:0]),
        .rdata (ram_rdata)
    );

    // Allocate checks: length, stack room, then page growth; free checks the stack is not empty
    always_comb begin
        with_hdr   = SUM_W'(used_reg) + SUM_W'(HEADER_BYTES);
        sum_end    = with_hdr + SUM_W'(item_reg.alloc_length);
        cap_grown  = SUM_W'(cap_reg) + SUM_W'(PAGE_BYTES);
        bad_len    = (item_reg.alloc_length == 12'd0) ||
                     (item_reg.alloc_length > max_alloc_reg);
        stack_full = (depth_reg == DEPTH_W'(MAX_DEPTH));
        need_page  = (sum_end > SUM_W'(cap_reg));
        page_fail  = need_page &&
                     ((32'(page_count_reg) >= 32'(page_limit_reg)) ||
                      (32'(page_count_reg) >= 32'(MAX_PAGES)) ||
                      (sum_end > cap_grown));
        alloc_ok   = (item_reg.mode == lpsa_pkg::MODE_ALLOC) &&
                     !bad_len && !stack_full && !page_fail;
        free_ok    = (item_reg.mode == lpsa_pkg::MODE_FREE) &&
                     (depth_reg != DEPTH_W'(0));

        res = '0;
        if (item_reg.mode == lpsa_pkg::MODE_ALLOC) begin
            if (bad_len) begin
                res.status = lpsa_pkg::ST_BAD_LENGTH;
            end else if (stack_full) begin
                res.status = lpsa_pkg::ST_STACK_FULL;
            end else if (page_fail) begin
                res.status = lpsa_pkg::ST_PAGE_LIMIT;
            end else begin
                res.status         = lpsa_pkg::ST_OK;
                res.buffer_offset  = 18'(with_hdr);
                res.page_requested = need_page;
            end
        end else begin
            if (!free_ok) begin
                res.status = lpsa_pkg::ST_STACK_EMPTY;
            end else begin
                res.status        = lpsa_pkg::ST_OK;
                res.freed_length  = pop_len;
                res.page_released = pop_grew;
            end
        end
    end

    assign stat.out_free = !m_valid_reg || m_ready;

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.commit) begin
            m_data_reg <= res;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            max_alloc_reg  <= lpsa_pkg::MAX_ALLOC_RST;
            page_limit_reg <= lpsa_pkg::PAGE_LIMIT_RST;
            depth_reg      <= '0;
            used_reg       <= '0;
            cap_reg        <= '0;
            page_count_reg <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (cfg_we) begin
                unique case (cfg_addr)
                    lpsa_pkg::CFG_MAX_ALLOC:  max_alloc_reg  <= cfg_wdata;
                    lpsa_pkg::CFG_PAGE_LIMIT: page_limit_reg <= cfg_wdata[6:0];
                    default: ;
                endcase
            end
            if (cmd.commit && alloc_ok) begin
                depth_reg <= depth_reg + DEPTH_W'(1);
                used_reg  <= USED_W'(sum_end);
                if (need_page) begin
                    page_count_reg <= page_count_reg + PC_W'(1);
                    cap_reg        <= cap_reg + USED_W'(PAGE_BYTES);
                end
            end else if (cmd.commit && free_ok) begin
                depth_reg <= depth_dec;
                used_reg  <= used_reg - USED_W'(HEADER_BYTES) - USED_W'(pop_len);
                if (pop_grew) begin
                    page_count_reg <= page_count_reg - PC_W'(1);
                    cap_reg        <= cap_reg - USED_W'(PAGE_BYTES);
                end
            end
            if (cmd.commit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

`ifndef NO_ASSERTIONS
    a_used_in_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        used_reg <= cap_reg)
        else $error("used bytes exceed held pages");

    a_cap_tracks_pages: assert property (@(posedge aclk) disable iff (!aresetn)
        32'(cap_reg) == 32'(page_count_reg) * 32'(PAGE_BYTES))
        else $error("capacity out of step with page count");

    a_commit_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    a_commit_shows: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> m_valid_reg)
        else $error("committed result not presented");

    a_no_double_cmd: assert property (@(posedge aclk) disable iff (!aresetn)
        !(cmd.accept && cmd.commit))
        else $error("accept and commit in one cycle");
`endif

endmodule

### hdl/lifo_page_stack_allocator.sv
// Top level of the LIFO page stack allocator: controller plus datapath.
//
//   Channel  | Direction | Handshake          | Payload
//   ---------+-----------+--------------------+-------------------------------
//   s_       | in        | s_valid / s_ready  | s_data  (mode, alloc_length)
//   m_       | out       | m_valid / m_ready  | m_data  (status, buffer_offset,
//            |           |                    |  freed_length, page flags)
//   cfg_     | in        | cfg_we             | cfg_addr, cfg_wdata
//
// Each transaction is accepted, then executed: the accept cycle issues the
// stack RAM read of the top entry for a free request, and execute uses the
// registered read data to decide and update the allocator state.
// A new request is accepted while the previous result still waits in the
// output register; execute then holds until that register is drained.
// Reset (aresetn, synchronous, active low) empties the stack, clears the
// used byte count and page count and restores the register defaults.
// The stack RAM is not cleared: only entries below the stack depth are read.
module lifo_page_stack_allocator #(
    parameter int PAGE_BYTES   = lpsa_pkg::PAGE_BYTES_DEF,
    parameter int HEADER_BYTES = lpsa_pkg::HEADER_BYTES_DEF,
    parameter int MAX_DEPTH    = lpsa_pkg::MAX_DEPTH_DEF,
    parameter int MAX_PAGES    = lpsa_pkg::MAX_PAGES_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    // request channel
    input  logic                            s_valid,
    output logic                            s_ready,
    input  lpsa_pkg::in_item_t              s_data,
    // result channel
    output logic                            m_valid,
    input  logic                            m_ready,
    output lpsa_pkg::result_t               m_data,
    // configuration write port
    input  logic                            cfg_we,
    input  logic [lpsa_pkg::CFG_ADDR_W-1:0] cfg_addr,
    input  logic [lpsa_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    lpsa_pkg::cmd_t  cmd;
    lpsa_pkg::stat_t stat;

    // Sequence accept and execute; one transaction in flight
    lpsa_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // Hold the stack, byte and page bookkeeping and the result register
    lpsa_dp #(
        .PAGE_BYTES   (PAGE_BYTES),
        .HEADER_BYTES (HEADER_BYTES),
        .MAX_DEPTH    (MAX_DEPTH),
        .MAX_PAGES    (MAX_PAGES)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd       (cmd),
        .stat      (stat),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

endmodule
